/* sv/c2sg_pkg.sv */
// c2sg_pkg: shared constants and the output clipping function for the
// Cartesian-to-spherical gradient block. No dependencies.
package c2sg_pkg;

  localparam int unsigned C2SG_IN_WIDTH  = 32;
  localparam int unsigned C2SG_FRAC_BITS = 16;
  localparam int unsigned C2SG_OUT_WIDTH = 48;
  // Wide enough for every internal component before clipping.
  localparam int unsigned C2SG_CLIP_W    = 2 * C2SG_OUT_WIDTH + 4;

  // Clip a signed value to the output range: returns {clipped, value}.
  function automatic logic [C2SG_OUT_WIDTH:0] c2sg_clip(
    input logic signed [C2SG_CLIP_W-1:0] v
  );
    logic [C2SG_CLIP_W-C2SG_OUT_WIDTH:0] upper;
    upper = v[C2SG_CLIP_W-1:C2SG_OUT_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      return {1'b0, v[C2SG_OUT_WIDTH-1:0]};
    end else if (v[C2SG_CLIP_W-1]) begin
      return {1'b1, 1'b1, {(C2SG_OUT_WIDTH-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(C2SG_OUT_WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

/* sv/cartesian_to_spherical_gradient.sv */
// Cartesian-to-spherical gradient transform, fully pipelined.
// Depends on c2sg_pkg for widths and the clipping function.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one cell centre and one
//   derivative vector per transfer. Output channel (out_valid_o /
//   out_ready_i) returns radial, azimuthal and polar parts with the
//   zero_radius and saturated flags, one result per input, in order.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes
//   three_d_mode; it is always ready and must only be used while idle.
//   An item passes 2*IN_WIDTH+8 register stages before its result is shown:
//   three stages of capture, products and sums, IN_WIDTH stages of
//   digit-by-digit square root, one stage of sign handling, IN_WIDTH+1
//   stages of restoring division, then quotient fix-up, the polar products
//   and the clip into the output register.
//   Throughput is one item per cycle. A stalled output holds the whole
//   pipeline: in_ready_o drops while the output register is full and not
//   being taken. Reset empties the pipeline and sets three_d_mode to 1.
module cartesian_to_spherical_gradient
  import c2sg_pkg::*;
#(
  parameter int unsigned FRAC_BITS = C2SG_FRAC_BITS,
  parameter int unsigned IN_WIDTH  = C2SG_IN_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_three_d_mode_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [IN_WIDTH-1:0]       coord_x_i,
  input  logic signed [IN_WIDTH-1:0]       coord_y_i,
  input  logic signed [IN_WIDTH-1:0]       coord_z_i,
  input  logic signed [IN_WIDTH-1:0]       grad_x_i,
  input  logic signed [IN_WIDTH-1:0]       grad_y_i,
  input  logic signed [IN_WIDTH-1:0]       grad_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [C2SG_OUT_WIDTH-1:0] radial_part_o,
  output logic signed [C2SG_OUT_WIDTH-1:0] azimuthal_part_o,
  output logic signed [C2SG_OUT_WIDTH-1:0] polar_part_o,
  output logic                             zero_radius_o,
  output logic                             saturated_o
);

  localparam int unsigned W    = IN_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned NW   = 2 * W + 1;
  localparam int unsigned AZW  = NW - F;
  localparam int unsigned RW   = W + 3;
  localparam int unsigned QW   = W + 1;
  localparam int unsigned DRW  = W + 1;
  localparam int unsigned QSW  = W + 2;
  localparam int unsigned ZQW  = W + QSW;
  localparam int unsigned RGW  = 2 * W + 1;
  localparam int unsigned PLW  = 2 * W + 3;
  localparam int unsigned PLSW = PLW - F;
  localparam int unsigned SAW  = 2 * NW + AZW + 2 * W + 1;
  localparam int unsigned SBW  = AZW + 4 * W + 5;
  localparam int unsigned OW   = C2SG_OUT_WIDTH;

  // One restoring square-root digit: returns {remainder, root}.
  function automatic logic [RW+W-1:0] sqrt_step(
    input logic [RW-1:0] rem,
    input logic [W-1:0]  root,
    input logic [1:0]    pair
  );
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    r2    = {rem[RW-3:0], pair};
    trial = RW'({root, 2'b01});
    if (r2 >= trial) begin
      return {r2 - trial, root[W-2:0], 1'b1};
    end else begin
      return {r2, root[W-2:0], 1'b0};
    end
  endfunction

  // One restoring division bit: returns {remainder, quotient}.
  function automatic logic [DRW+QW-1:0] div_step(
    input logic [DRW-1:0] rem,
    input logic [W-1:0]   d,
    input logic           nbit,
    input logic [QW-1:0]  q
  );
    logic [DRW-1:0] r2;
    r2 = {rem[DRW-2:0], nbit};
    if (r2 >= {1'b0, d}) begin
      return {r2 - {1'b0, d}, q[QW-2:0], 1'b1};
    end else begin
      return {r2, q[QW-2:0], 1'b0};
    end
  endfunction

  logic en;
  logic mode_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_three_d_mode_i;
    end
  end

  // ---------------- stage 0: input capture ----------------
  logic                v0_q;
  logic signed [W-1:0] x0_q, y0_q, z0_q, gx0_q, gy0_q, gz0_q;
  logic                mode0_q;

  // ---------------- stage 1: products ----------------
  logic                 v1_q;
  logic signed [PW-1:0] xx_q, yy_q, zz_q, xgx_q, ygy_q, zgz_q, xgy_q, ygx_q;
  logic signed [W-1:0]  z1_q, gz1_q;
  logic                 mode1_q;

  // ---------------- stage 2: sums ----------------
  logic                  v2_q;
  logic [PW-1:0]         s2_q, s3_q;
  logic signed [NW-1:0]  np_q, nr_q;
  logic signed [AZW-1:0] az_q;
  logic signed [W-1:0]   z2_q, gz2_q;
  logic                  mode2_q;
  logic signed [NW-1:0]  az_full;
  logic [SAW-1:0]        side_s2;

  assign az_full = NW'(xgy_q) - NW'(ygx_q);
  assign side_s2 = {np_q, nr_q, az_q, z2_q, gz2_q, mode2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q    <= coord_x_i;
      y0_q    <= coord_y_i;
      z0_q    <= coord_z_i;
      gx0_q   <= grad_x_i;
      gy0_q   <= grad_y_i;
      gz0_q   <= grad_z_i;
      mode0_q <= mode_q;

      xx_q    <= x0_q * x0_q;
      yy_q    <= y0_q * y0_q;
      zz_q    <= z0_q * z0_q;
      xgx_q   <= x0_q * gx0_q;
      ygy_q   <= y0_q * gy0_q;
      zgz_q   <= z0_q * gz0_q;
      xgy_q   <= x0_q * gy0_q;
      ygx_q   <= y0_q * gx0_q;
      z1_q    <= z0_q;
      gz1_q   <= gz0_q;
      mode1_q <= mode0_q;

      s2_q    <= $unsigned(xx_q) + $unsigned(yy_q);
      s3_q    <= $unsigned(xx_q) + $unsigned(yy_q) + $unsigned(zz_q);
      np_q    <= NW'(xgx_q) + NW'(ygy_q);
      nr_q    <= NW'(xgx_q) + NW'(ygy_q) + NW'(zgz_q);
      az_q    <= $signed(az_full[NW-1:F]);
      z2_q    <= z1_q;
      gz2_q   <= gz1_q;
      mode2_q <= mode1_q;
    end
  end

  // ---------------- square roots, one digit per stage ----------------
  logic [RW-1:0]  sqa_rem_q  [W];
  logic [W-1:0]   sqa_root_q [W];
  logic [PW-1:0]  sqa_src_q  [W];
  logic [RW-1:0]  sqb_rem_q  [W];
  logic [W-1:0]   sqb_root_q [W];
  logic [PW-1:0]  sqb_src_q  [W];
  logic [SAW-1:0] sq_side_q  [W];
  logic           sq_v_q     [W];

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic [RW-1:0]   ra_in, rb_in;
    logic [W-1:0]    oa_in, ob_in;
    logic [PW-1:0]   sa_in, sb_in;
    logic [SAW-1:0]  side_in;
    logic            v_in;
    logic [RW+W-1:0] na, nb;

    if (k == 0) begin : g_first
      assign ra_in   = '0;
      assign rb_in   = '0;
      assign oa_in   = '0;
      assign ob_in   = '0;
      assign sa_in   = s2_q;
      assign sb_in   = s3_q;
      assign side_in = side_s2;
      assign v_in    = v2_q;
    end else begin : g_next
      assign ra_in   = sqa_rem_q[k-1];
      assign rb_in   = sqb_rem_q[k-1];
      assign oa_in   = sqa_root_q[k-1];
      assign ob_in   = sqb_root_q[k-1];
      assign sa_in   = sqa_src_q[k-1];
      assign sb_in   = sqb_src_q[k-1];
      assign side_in = sq_side_q[k-1];
      assign v_in    = sq_v_q[k-1];
    end

    assign na = sqrt_step(ra_in, oa_in, sa_in[PW-1 -: 2]);
    assign nb = sqrt_step(rb_in, ob_in, sb_in[PW-1 -: 2]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqa_rem_q[k]  <= na[RW+W-1:W];
        sqa_root_q[k] <= na[W-1:0];
        sqa_src_q[k]  <= {sa_in[PW-3:0], 2'b00};
        sqb_rem_q[k]  <= nb[RW+W-1:W];
        sqb_root_q[k] <= nb[W-1:0];
        sqb_src_q[k]  <= {sb_in[PW-3:0], 2'b00};
        sq_side_q[k]  <= side_in;
      end
    end
  end

  // ---------------- sign handling before division ----------------
  logic signed [NW-1:0]  np_e, nr_e;
  logic signed [AZW-1:0] az_e;
  logic signed [W-1:0]   z_e, gz_e;
  logic                  mode_e;
  logic [W-1:0]          rp_e, rs_e;
  logic [NW-1:0]         np_mag, nr_mag;

  assign {np_e, nr_e, az_e, z_e, gz_e, mode_e} = sq_side_q[W-1];
  assign rp_e   = sqa_root_q[W-1];
  assign rs_e   = sqb_root_q[W-1];
  assign np_mag = np_e[NW-1] ? -np_e : np_e;
  assign nr_mag = nr_e[NW-1] ? -nr_e : nr_e;

  logic           vp_q;
  logic [PW-1:0]  nmp_q, nmr_q;
  logic [SBW-1:0] sidep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= sq_v_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nmp_q   <= np_mag[PW-1:0];
      nmr_q   <= nr_mag[PW-1:0];
      sidep_q <= {az_e, z_e, gz_e, rp_e, rs_e, mode_e, np_e[NW-1], nr_e[NW-1],
                  rp_e == '0, rs_e == '0};
    end
  end

  // ---------------- divisions, one quotient bit per stage ----------------
  logic [DRW-1:0] dva_rem_q [QW];
  logic [QW-1:0]  dva_q_q   [QW];
  logic [QW-1:0]  dva_src_q [QW];
  logic [DRW-1:0] dvb_rem_q [QW];
  logic [QW-1:0]  dvb_q_q   [QW];
  logic [QW-1:0]  dvb_src_q [QW];
  logic [SBW-1:0] dv_side_q [QW];
  logic           dv_v_q    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DRW-1:0]    ra_in, rb_in;
    logic [QW-1:0]     qa_in, qb_in, sa_in, sb_in;
    logic [SBW-1:0]    side_in;
    logic              v_in;
    logic [DRW+QW-1:0] na, nb;
    logic [W-1:0]      da, db;

    if (k == 0) begin : g_first
      assign ra_in   = DRW'(nmp_q[PW-1:QW]);
      assign rb_in   = DRW'(nmr_q[PW-1:QW]);
      assign qa_in   = '0;
      assign qb_in   = '0;
      assign sa_in   = nmp_q[QW-1:0];
      assign sb_in   = nmr_q[QW-1:0];
      assign side_in = sidep_q;
      assign v_in    = vp_q;
    end else begin : g_next
      assign ra_in   = dva_rem_q[k-1];
      assign rb_in   = dvb_rem_q[k-1];
      assign qa_in   = dva_q_q[k-1];
      assign qb_in   = dvb_q_q[k-1];
      assign sa_in   = dva_src_q[k-1];
      assign sb_in   = dvb_src_q[k-1];
      assign side_in = dv_side_q[k-1];
      assign v_in    = dv_v_q[k-1];
    end

    // Divisors sit in the side word: planar then spherical radius.
    assign da = side_in[2*W+4 -: W];
    assign db = side_in[W+4 -: W];
    assign na = div_step(ra_in, da, sa_in[QW-1], qa_in);
    assign nb = div_step(rb_in, db, sb_in[QW-1], qb_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (en) begin
        dv_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dva_rem_q[k] <= na[DRW+QW-1:QW];
        dva_q_q[k]   <= na[QW-1:0];
        dva_src_q[k] <= {sa_in[QW-2:0], 1'b0};
        dvb_rem_q[k] <= nb[DRW+QW-1:QW];
        dvb_q_q[k]   <= nb[QW-1:0];
        dvb_src_q[k] <= {sb_in[QW-2:0], 1'b0};
        dv_side_q[k] <= side_in;
      end
    end
  end

  // ---------------- quotient fix-up ----------------
  logic signed [AZW-1:0] az_d;
  logic signed [W-1:0]   z_d, gz_d;
  logic [W-1:0]          rp_d;
  logic                  mode_d, negp_d, negr_d, zp_d, zs_d;
  logic signed [QSW-1:0] qp_s, qr_s;

  // The spherical radius between these two slices is no longer needed.
  assign {az_d, z_d, gz_d, rp_d} = dv_side_q[QW-1][SBW-1:W+5];
  assign {mode_d, negp_d, negr_d, zp_d, zs_d} = dv_side_q[QW-1][4:0];
  assign qp_s = negp_d ? -$signed({1'b0, dva_q_q[QW-1]}) : $signed({1'b0, dva_q_q[QW-1]});
  assign qr_s = negr_d ? -$signed({1'b0, dvb_q_q[QW-1]}) : $signed({1'b0, dvb_q_q[QW-1]});

  logic                  vq_q;
  logic signed [QSW-1:0] q_q, rad_q;
  logic signed [AZW-1:0] azq_q;
  logic signed [W-1:0]   zq_in_q, gzq_q;
  logic [W-1:0]          rpq_q;
  logic                  modeq_q, zeroq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q     <= zp_d ? '0 : qp_s;
      if (mode_d) begin
        rad_q <= zs_d ? '0 : qr_s;
      end else begin
        rad_q <= zp_d ? '0 : qp_s;
      end
      zeroq_q <= zp_d || (mode_d && zs_d);
      azq_q   <= az_d;
      zq_in_q <= z_d;
      gzq_q   <= gz_d;
      rpq_q   <= rp_d;
      modeq_q <= mode_d;
    end
  end

  // ---------------- polar products ----------------
  logic                  vm_q;
  logic signed [ZQW-1:0] zq_q;
  logic signed [RGW-1:0] rpg_q;
  logic signed [QSW-1:0] radm_q;
  logic signed [AZW-1:0] azm_q;
  logic                  modem_q, zerom_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zq_q    <= zq_in_q * q_q;
      rpg_q   <= $signed({1'b0, rpq_q}) * gzq_q;
      radm_q  <= rad_q;
      azm_q   <= azq_q;
      modem_q <= modeq_q;
      zerom_q <= zeroq_q;
    end
  end

  // ---------------- clip and output register ----------------
  logic signed [PLW-1:0]  pl_full;
  logic signed [PLSW-1:0] pl_s;
  logic [OW:0]            clip_r, clip_a, clip_p;

  assign pl_full = PLW'(zq_q) - PLW'(rpg_q);
  assign pl_s    = modem_q ? $signed(pl_full[PLW-1:F]) : '0;
  assign clip_r  = c2sg_clip(C2SG_CLIP_W'(radm_q));
  assign clip_a  = c2sg_clip(C2SG_CLIP_W'(azm_q));
  assign clip_p  = c2sg_clip(C2SG_CLIP_W'(pl_s));

  logic vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vq_q <= dv_v_q[QW-1];
      vm_q <= vq_q;
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radial_part_o    <= $signed(clip_r[OW-1:0]);
      azimuthal_part_o <= $signed(clip_a[OW-1:0]);
      polar_part_o     <= $signed(clip_p[OW-1:0]);
      zero_radius_o    <= zerom_q;
      saturated_o      <= clip_r[OW] || clip_a[OW] || clip_p[OW];
    end
  end

  assign out_valid_o = vo_q;

endmodule

/* sv/c2sg_checker.sv */
// c2sg_checker: port-level assertions for the gradient transform, bound to
// the top level below. Depends on c2sg_pkg for the output width.
module c2sg_checker
  import c2sg_pkg::*;
(
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [C2SG_OUT_WIDTH-1:0] radial_part_o,
  input logic signed [C2SG_OUT_WIDTH-1:0] azimuthal_part_o,
  input logic signed [C2SG_OUT_WIDTH-1:0] polar_part_o,
  input logic                             saturated_o
);

  localparam logic [C2SG_OUT_WIDTH-1:0] MaxV = {1'b0, {(C2SG_OUT_WIDTH-1){1'b1}}};
  localparam logic [C2SG_OUT_WIDTH-1:0] MinV = {1'b1, {(C2SG_OUT_WIDTH-1){1'b0}}};

  // A waiting result stays until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(radial_part_o))
    else $error("result dropped or changed while stalled");

  // An empty output register never blocks the input side.
  a_take_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Draining output implies room for a new transfer.
  a_take_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // A clipped result shows a range end in some component.
  a_sat_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      radial_part_o == MaxV || radial_part_o == MinV ||
      azimuthal_part_o == MaxV || azimuthal_part_o == MinV ||
      polar_part_o == MaxV || polar_part_o == MinV)
    else $error("saturated flag without clipped component");

endmodule

bind cartesian_to_spherical_gradient c2sg_checker u_c2sg_checker (.*);
